### src/bpg_pkg.sv
// ---------------------------------------------------------------------------
// bpg_pkg
// Shared types and constants for the bit-plane popcount GEMV accumulator.
// ---------------------------------------------------------------------------
package bpg_pkg;

	// lane geometry: one 64-bit word of each plane per lane
	localparam int NUM_LANES = 4;
	localparam int LANE_W    = 64;
	localparam int CNT_W     = 7;
	localparam int PC_W      = 9;

	// unpacked float: value = sig * 2^exp
	localparam int EXP_W = 11;
	localparam int SIG_W = 32;

	localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
	localparam logic [15:0] F16_QNAN = 16'h7E00;

	typedef struct packed {
		logic                    nan;
		logic                    inf;
		logic                    sign;
		logic signed [EXP_W-1:0] exp;
		logic [SIG_W-1:0]        sig;
	} ufp_t;

	// request from the sequencer to the adder
	typedef struct packed {
		logic start;
		ufp_t op_a;
		ufp_t op_b;
	} fadd_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_BIAS,
		ST_CONV
	} state_t;

endpackage

### src/bpg_lane.sv
// ---------------------------------------------------------------------------
// bpg_lane
// One popcount lane: counts set bits of left AND right over the valid bytes
// of one 64-bit word and registers the count.
// ---------------------------------------------------------------------------
module bpg_lane
	import bpg_pkg::*;
#(
	parameter int NBYTES = 8
) (
	input  logic              clk,
	input  logic              ld,
	input  logic [LANE_W-1:0] left,
	input  logic [LANE_W-1:0] right,
	output logic [CNT_W-1:0]  cnt
);

	// bytes past the block are dropped
	localparam logic [LANE_W-1:0] MASK = (NBYTES >= 8) ? {LANE_W{1'b1}} :
		((LANE_W'(1) << (8 * NBYTES)) - LANE_W'(1));

	logic [CNT_W-1:0] cnt_s1;

	function automatic logic [CNT_W-1:0] popcnt(input logic [LANE_W-1:0] v);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < LANE_W; i++) c = c + CNT_W'(v[i]);
		return c;
	endfunction

	// count register, loaded with each transaction
	always_ff @(posedge clk) begin
		if (ld) begin
			cnt_s1 <= popcnt(left & right & MASK);
		end
	end

	assign cnt = cnt_s1;

endmodule

### src/bpg_fadd.sv
// ---------------------------------------------------------------------------
// bpg_fadd
// Five-stage fp32 adder for unpacked operands with up to 32-bit
// significands; one rounding, nearest-even, subnormals kept.
// ---------------------------------------------------------------------------
module bpg_fadd
	import bpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fadd_req_t   req,
	output logic        done,
	output logic [31:0] result
);

	logic v_s1, v_s2, v_s3, v_s4, done_q;

	logic        spec_s1, spec_s2, spec_s3, spec_s4;
	logic [31:0] sbits_s1, sbits_s2, sbits_s3, sbits_s4;
	ufp_t        na_s1, nb_s1;

	logic [63:0]             big_s2, minor_s2;
	logic                    sub_s2, sign_s2, zsign_s2;
	logic signed [EXP_W-1:0] e_s2;

	logic [64:0]             mag_s3;
	logic                    sign_s3, zsign_s3;
	logic signed [EXP_W-1:0] e_s3;

	logic [64:0]             norm_s4;
	logic signed [11:0]      emsb_s4;
	logic                    sign_s4, zero_s4;

	logic [31:0] result_q;

	function automatic logic [5:0] lzc32(input logic [31:0] v);
		logic [5:0] n;
		logic       f;
		n = 6'd32;
		f = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!f && v[i]) begin
				n = 6'(31 - i);
				f = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [6:0] lzc65(input logic [64:0] v);
		logic [6:0] n;
		logic       f;
		n = 7'd65;
		f = 1'b0;
		for (int i = 64; i >= 0; i--) begin
			if (!f && v[i]) begin
				n = 7'(64 - i);
				f = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic ufp_t norm32(input ufp_t x);
		ufp_t       r;
		logic [5:0] lz;
		lz    = lzc32(x.sig);
		r     = x;
		r.sig = x.sig << lz;
		r.exp = x.exp - EXP_W'(lz);
		return r;
	endfunction

	// stage 1: special cases, normalize both significands
	logic        s1_nan, s1_inf, s1_isg;
	always_comb begin
		s1_nan = req.op_a.nan | req.op_b.nan |
			(req.op_a.inf & req.op_b.inf & (req.op_a.sign != req.op_b.sign));
		s1_inf = req.op_a.inf | req.op_b.inf;
		s1_isg = req.op_a.inf ? req.op_a.sign : req.op_b.sign;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			na_s1    <= norm32(req.op_a);
			nb_s1    <= norm32(req.op_b);
			spec_s1  <= s1_nan | s1_inf;
			sbits_s1 <= s1_nan ? F32_QNAN : {s1_isg, 8'hFF, 23'd0};
		end
	end

	// stage 2: order by exponent, align smaller with sticky
	ufp_t               big, minor;
	logic               az, bz, swap;
	logic signed [11:0] diff;
	logic [6:0]         dsh;
	logic [63:0]        ext, shd;
	logic               st2;
	always_comb begin
		az   = (na_s1.sig == '0);
		bz   = (nb_s1.sig == '0);
		swap = az | (!bz && ($signed(nb_s1.exp) > $signed(na_s1.exp)));
		big  = swap ? nb_s1 : na_s1;
		minor = swap ? na_s1 : nb_s1;
		diff = $signed({big.exp[EXP_W-1], big.exp}) -
			$signed({minor.exp[EXP_W-1], minor.exp});
		if (diff < 0) dsh = 7'd0;
		else if (diff >= 64) dsh = 7'd64;
		else dsh = diff[6:0];
		ext = {minor.sig, 32'd0};
		shd = ext >> dsh;
		st2 = |(ext & ~({64{1'b1}} << dsh));
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			big_s2   <= {big.sig, 32'd0};
			minor_s2 <= shd | {63'd0, st2};
			sub_s2   <= big.sign ^ minor.sign;
			sign_s2  <= big.sign;
			zsign_s2 <= na_s1.sign & nb_s1.sign;
			e_s2     <= big.exp;
			spec_s2  <= spec_s1;
			sbits_s2 <= sbits_s1;
		end
	end

	// stage 3: add or subtract magnitudes
	logic [65:0] s66;
	logic        neg;
	always_comb begin
		s66 = sub_s2 ? ({2'b0, big_s2} - {2'b0, minor_s2}) :
			({2'b0, big_s2} + {2'b0, minor_s2});
		neg = sub_s2 & s66[65];
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			mag_s3   <= neg ? 65'(-s66) : s66[64:0];
			sign_s3  <= sign_s2 ^ neg;
			zsign_s3 <= zsign_s2;
			e_s3     <= e_s2;
			spec_s3  <= spec_s2;
			sbits_s3 <= sbits_s2;
		end
	end

	// stage 4: normalize sum to bit 64
	logic [6:0] lz4;
	always_comb begin
		lz4 = lzc65(mag_s3);
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			norm_s4  <= mag_s3 << lz4;
			emsb_s4  <= 12'($signed(e_s3)) + 12'sd32 - $signed({5'd0, lz4});
			zero_s4  <= (mag_s3 == '0);
			sign_s4  <= (mag_s3 == '0) ? zsign_s3 : sign_s3;
			spec_s4  <= spec_s3;
			sbits_s4 <= sbits_s3;
		end
	end

	// stage 5: subnormal shift, round to nearest even, pack
	logic               den, ovf, g5, st5, inc5, inf5;
	logic signed [11:0] dd;
	logic [6:0]         s5;
	logic [64:0]        t5;
	logic [24:0]        r5;
	logic [8:0]         base5;
	logic [31:0]        bits5, res5;
	always_comb begin
		den = (emsb_s4 < -12'sd126);
		ovf = (emsb_s4 > 12'sd127);
		dd  = -12'sd126 - emsb_s4;
		if (!den) s5 = 7'd0;
		else if (dd > 12'sd66) s5 = 7'd66;
		else s5 = dd[6:0];
		t5    = norm_s4 >> s5;
		g5    = t5[40];
		st5   = (|t5[39:0]) | (|(norm_s4 & ~({65{1'b1}} << s5)));
		inc5  = g5 & (st5 | t5[41]);
		r5    = {1'b0, t5[64:41]} + 25'(inc5);
		base5 = den ? 9'd0 : 9'(emsb_s4 + 12'sd126);
		bits5 = {base5[7:0], 23'd0} + 32'(r5);
		inf5  = ovf | (bits5[30:23] == 8'hFF);
		if (spec_s4) res5 = sbits_s4;
		else if (zero_s4) res5 = {sign_s4, 31'd0};
		else if (inf5) res5 = {sign_s4, 8'hFF, 23'd0};
		else res5 = {sign_s4, bits5[30:0]};
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			result_q <= res5;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= req.start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### src/bitplane_popcount_gemv_accumulator_top.sv
// ---------------------------------------------------------------------------
// bitplane_popcount_gemv_accumulator_top
// Column accumulator for a bit-plane quantized matrix-vector product.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one term per transaction, two 256-bit
// plane blocks as four 64-bit words each, two binary16 coefficients, the
// binary16 bias and last_term. Four lanes count AND-ed bits per word; the
// merge adds the counts and scales the coefficient product by them.
// The product is added into the fp32 running sum by a five-stage adder.
// A term occupies the block from acceptance through the merge/multiply and the
// five adder stages, so a new term is taken only after its sum is written back.
// A last term then goes through the fp16 conversion, after a second pass
// through the adder for the bias when the bias is enabled; out_valid rises once
// the converted result is loaded into the output register.
// Output channel (out_valid/column_result): one output register. While it
// waits for out_ready the block keeps accepting and accumulating terms; only
// the next last term waits at conversion until the register frees up.
// Reset clears the running sum to +0, bias_enable to 0 and the output valid.
// cfg_write_en/cfg_write_data write bias_enable; write only when idle.
// ---------------------------------------------------------------------------
module bitplane_popcount_gemv_accumulator_top
	import bpg_pkg::*;
#(
	parameter int BLOCK_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] left_bits_0,
	input  logic [63:0] left_bits_1,
	input  logic [63:0] left_bits_2,
	input  logic [63:0] left_bits_3,
	input  logic [63:0] right_bits_0,
	input  logic [63:0] right_bits_1,
	input  logic [63:0] right_bits_2,
	input  logic [63:0] right_bits_3,
	input  logic [15:0] left_coeff,
	input  logic [15:0] right_coeff,
	input  logic [15:0] bias_value,
	input  logic        last_term,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] column_result,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data
);

	state_t state_q, state_d;

	logic              acc;
	logic [LANE_W-1:0] left_w  [NUM_LANES];
	logic [LANE_W-1:0] right_w [NUM_LANES];
	logic [CNT_W-1:0]  cnt     [NUM_LANES];

	logic                    bias_en_q;
	logic [21:0]             psig_s1;
	logic signed [EXP_W-1:0] pexp_s1;
	logic                    psign_s1, nan_s1, inf_a_s1, inf_b_s1, zero_a_s1, zero_b_s1;
	logic [15:0]             bias_q;
	logic                    last_q;
	logic [31:0]             sum_q, res_q;
	logic [15:0]             out_q;
	logic                    out_valid_q;

	fadd_req_t   req;
	logic        add_done;
	logic [31:0] add_res;
	logic        sum_ld, sum_clr, res_ld, out_ld;
	logic [31:0] sum_nx;

	function automatic ufp_t unpack16(input logic [15:0] h);
		ufp_t r;
		r.sign = h[15];
		r.nan  = (h[14:10] == 5'h1F) && (h[9:0] != '0);
		r.inf  = (h[14:10] == 5'h1F) && (h[9:0] == '0);
		r.sig  = (h[14:10] == 5'h1F) ? '0 :
			SIG_W'({(h[14:10] != 5'd0), h[9:0]});
		r.exp  = (h[14:10] == 5'd0) ? EXP_W'(-24) :
			$signed(EXP_W'(h[14:10])) - EXP_W'(25);
		return r;
	endfunction

	function automatic ufp_t unpack32(input logic [31:0] f);
		ufp_t r;
		r.sign = f[31];
		r.nan  = (f[30:23] == 8'hFF) && (f[22:0] != '0);
		r.inf  = (f[30:23] == 8'hFF) && (f[22:0] == '0);
		r.sig  = (f[30:23] == 8'hFF) ? '0 : SIG_W'({(f[30:23] != 8'd0), f[22:0]});
		r.exp  = (f[30:23] == 8'd0) ? EXP_W'(-149) :
			$signed(EXP_W'(f[30:23])) - EXP_W'(150);
		return r;
	endfunction

	// fp32 to fp16; rounding works on 25 bits so a shift of 25 keeps its half point
	function automatic logic [15:0] f32_to_f16(input logic [31:0] b);
		logic              sg;
		logic [7:0]        e;
		logic [24:0]       mant, q, rem, half;
		logic signed [9:0] ex, t, ep;
		logic [4:0]        sh;
		logic [15:0]       r;
		sg   = b[31];
		e    = b[30:23];
		mant = {1'b0, (e != 8'd0), b[22:0]};
		ex   = (e != 8'd0) ? ($signed({2'b0, e}) - 10'sd127) : -10'sd126;
		t    = -10'sd1 - ex;
		ep   = ex + 10'sd14;
		sh   = (ex >= -10'sd14) ? 5'd13 : t[4:0];
		q    = mant >> sh;
		rem  = mant & ~(25'h1FF_FFFF << sh);
		half = 25'd1 << (sh - 5'd1);
		if (rem > half || (rem == half && q[0])) q = q + 25'd1;
		if (e == 8'hFF) r = (b[22:0] != '0) ? F16_QNAN : {sg, 15'h7C00};
		else if (ex > 10'sd15) r = {sg, 15'h7C00};
		else if (ex < -10'sd26) r = {sg, 15'd0};
		else if (ex >= -10'sd14) r = {sg, {ep[4:0], 10'd0} + q[14:0]};
		else r = {sg, q[14:0]};
		return r;
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid & in_ready;

	// popcount lanes
	assign left_w[0]  = left_bits_0;
	assign left_w[1]  = left_bits_1;
	assign left_w[2]  = left_bits_2;
	assign left_w[3]  = left_bits_3;
	assign right_w[0] = right_bits_0;
	assign right_w[1] = right_bits_1;
	assign right_w[2] = right_bits_2;
	assign right_w[3] = right_bits_3;

	for (genvar w = 0; w < NUM_LANES; w++) begin : g_lane
		localparam int NB = (BLOCK_BYTES - 8 * w <= 0) ? 0 :
			((BLOCK_BYTES - 8 * w >= 8) ? 8 : BLOCK_BYTES - 8 * w);
		bpg_lane #(.NBYTES(NB)) u_lane (
			.clk   (clk),
			.ld    (acc),
			.left  (left_w[w]),
			.right (right_w[w]),
			.cnt   (cnt[w])
		);
	end

	// coefficient decode and significand product
	ufp_t ca, cb;
	always_comb begin
		ca = unpack16(left_coeff);
		cb = unpack16(right_coeff);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			psig_s1   <= ca.sig[10:0] * cb.sig[10:0];
			pexp_s1   <= ca.exp + cb.exp;
			psign_s1  <= ca.sign ^ cb.sign;
			nan_s1    <= ca.nan | cb.nan;
			inf_a_s1  <= ca.inf;
			inf_b_s1  <= cb.inf;
			zero_a_s1 <= !ca.inf && !ca.nan && (ca.sig == '0);
			zero_b_s1 <= !cb.inf && !cb.nan && (cb.sig == '0);
			bias_q    <= bias_value;
			last_q    <= last_term;
		end
	end

	// merge: total count, scaled product operand
	logic [PC_W-1:0] pc;
	ufp_t            prod;
	logic            pnan;
	always_comb begin
		pc = '0;
		for (int i = 0; i < NUM_LANES; i++) pc = pc + PC_W'(cnt[i]);
		pnan = nan_s1 | ((inf_a_s1 | inf_b_s1) &
			(zero_a_s1 | zero_b_s1 | (pc == '0)));
		prod.nan  = pnan;
		prod.inf  = (inf_a_s1 | inf_b_s1) & !pnan;
		prod.sign = psign_s1;
		prod.exp  = pexp_s1;
		prod.sig  = {10'd0, psig_s1} * {{(SIG_W - PC_W){1'b0}}, pc};
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		req     = '0;
		sum_ld  = 1'b0;
		sum_clr = 1'b0;
		res_ld  = 1'b0;
		out_ld  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) state_d = ST_MUL;
			end
			ST_MUL: begin
				req.start = 1'b1;
				req.op_a  = unpack32(sum_q);
				req.op_b  = prod;
				state_d   = ST_ADD;
			end
			ST_ADD: begin
				if (add_done) begin
					if (!last_q) begin
						sum_ld  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						sum_clr = 1'b1;
						if (bias_en_q) begin
							req.start = 1'b1;
							req.op_a  = unpack32(add_res);
							req.op_b  = unpack16(bias_q);
							state_d   = ST_BIAS;
						end else begin
							res_ld  = 1'b1;
							state_d = ST_CONV;
						end
					end
				end
			end
			ST_BIAS: begin
				if (add_done) begin
					res_ld  = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (!out_valid_q || out_ready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	bpg_fadd u_fadd (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (add_done),
		.result (add_res)
	);

	assign sum_nx = sum_clr ? 32'd0 : add_res;

	// control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bias_en_q   <= 1'b0;
			sum_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) bias_en_q <= cfg_write_data;
			if (sum_ld || sum_clr) sum_q <= sum_nx;
			if (out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// result and output registers
	always_ff @(posedge clk) begin
		if (res_ld) res_q <= add_res;
		if (out_ld) out_q <= f32_to_f16(res_q);
	end

	assign out_valid     = out_valid_q;
	assign column_result = out_q;

endmodule
